// File: src/hqs_pkg.sv
`default_nettype none
package hqs_pkg;
	localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;
endpackage
`default_nettype wire

// File: src/hqs_ram.sv
`default_nettype none
module hqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/hybrid_quicksort_engine_unit.sv
`default_nettype none
// single element: loading is followed by the segment check, stack pop, memory read and output states
// sort: each segment is popped from the stack; a partition scans element by element with swaps,
//   and insertion handles one key at a time with shifts
// throughput: one input transfer per cycle while loading; input is held off from the last
//   transfer until the final result is taken; each output is read after the previous is taken
// asynchronous active-low reset returns to loading with an empty set; memories are not cleared
module hybrid_quicksort_engine_unit #(
	parameter int DEPTH            = 64,
	parameter int INSERTION_CUTOFF = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // value
	input  wire logic        s_tlast,  // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // sorted_value
	output logic             m_tlast   // last_res
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] CUT_C   = CW'(INSERTION_CUTOFF);

	localparam logic [4:0] ST_LOAD = 5'd0, ST_POP = 5'd1, ST_POPW = 5'd2, ST_SEG = 5'd3,
		ST_MA = 5'd4, ST_MB = 5'd5, ST_MC = 5'd6, ST_MPICK = 5'd7, ST_MSW = 5'd8,
		ST_PRD = 5'd9, ST_PCMP = 5'd10, ST_PSWA = 5'd11, ST_PSWB = 5'd12, ST_PFIN = 5'd13,
		ST_PFA = 5'd14, ST_PFB = 5'd15, ST_PUSH1 = 5'd16, ST_PUSH2 = 5'd17, ST_II = 5'd18,
		ST_IKEY = 5'd19, ST_ICMP = 5'd20, ST_IRD = 5'd21, ST_OUTR = 5'd22, ST_OUTW = 5'd23,
		ST_OUT = 5'd24;

	logic [4:0] state_q;
	logic [CW-1:0] cnt_q, sp_q, lo_q, n_q, idx_q, st_q, i_q, j_q, pk_q;
	logic [31:0] a_q, b_q, c_q, piv_q, key_q, v_q, tmp_q;

	logic          e_we;
	logic [AW-1:0] e_wa, e_ra;
	logic [31:0]   e_wd, e_rd;
	logic          k_we;
	logic [AW-1:0] k_wa, k_ra;
	logic [2*CW-1:0] k_wd, k_rd;

	hqs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_elem (
		.clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
	hqs_ram #(.WIDTH(2*CW), .DEPTH(DEPTH)) u_stack (
		.clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

	logic [CW-1:0] mid, lst, rlen, pick_idx;
	logic [31:0]   pick_val;
	logic          last_scan;
	assign mid       = lo_q + (n_q >> 1);
	assign lst       = lo_q + n_q - CW'(1);
	assign rlen      = n_q - st_q - CW'(1);
	assign last_scan = (idx_q + CW'(1) == n_q - CW'(1));

	assign s_tready = (state_q == ST_LOAD);

	// median of first, middle and last
	always_comb begin
		if ((a_q <= b_q && b_q <= c_q) || (c_q <= b_q && b_q <= a_q)) begin
			pick_idx = mid; pick_val = b_q;
		end else if ((a_q <= c_q && c_q <= b_q) || (b_q <= c_q && c_q <= a_q)) begin
			pick_idx = lst; pick_val = c_q;
		end else begin
			pick_idx = lo_q; pick_val = a_q;
		end
	end

	always_comb begin
		e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
		k_we = 1'b0; k_wa = sp_q[AW-1:0]; k_wd = '0; k_ra = '0;
		unique case (state_q)
			ST_LOAD: begin
				e_we = s_tvalid && (cnt_q < DEPTH_C);
				e_wa = cnt_q[AW-1:0];
				e_wd = s_tdata ^ hqs_pkg::SIGN_FLIP;
			end
			ST_POP:   k_ra = AW'(sp_q - CW'(1));
			ST_SEG:   e_ra = lo_q[AW-1:0];
			ST_MA:    e_ra = mid[AW-1:0];
			ST_MB:    e_ra = lst[AW-1:0];
			ST_MPICK: begin
				e_we = 1'b1; e_wa = lst[AW-1:0]; e_wd = pick_val;
			end
			ST_MSW: begin
				e_we = 1'b1; e_wa = pk_q[AW-1:0]; e_wd = c_q;
			end
			ST_PRD:   e_ra = AW'(lo_q + idx_q);
			ST_PCMP:  e_ra = AW'(lo_q + st_q);
			ST_PSWA: begin
				e_we = 1'b1; e_wa = AW'(lo_q + st_q); e_wd = v_q;
			end
			ST_PSWB: begin
				e_we = 1'b1; e_wa = AW'(lo_q + idx_q); e_wd = tmp_q;
			end
			ST_PFIN:  e_ra = AW'(lo_q + st_q);
			ST_PFA: begin
				e_we = 1'b1; e_wa = lst[AW-1:0]; e_wd = e_rd;
			end
			ST_PFB: begin
				e_we = 1'b1; e_wa = AW'(lo_q + st_q); e_wd = piv_q;
			end
			ST_PUSH1: begin
				k_we = (st_q >= CW'(2)) && (sp_q < DEPTH_C);
				k_wd = {lo_q, st_q};
			end
			ST_PUSH2: begin
				k_we = (rlen >= CW'(2)) && (sp_q < DEPTH_C);
				k_wd = {CW'(lo_q + st_q + CW'(1)), rlen};
			end
			ST_II:    e_ra = AW'(lo_q + i_q);
			ST_IKEY:  e_ra = AW'(lo_q + i_q - CW'(1));
			ST_IRD: begin
				if (j_q == '0) begin
					e_we = 1'b1; e_wa = lo_q[AW-1:0]; e_wd = key_q;
				end else begin
					e_ra = AW'(lo_q + j_q - CW'(1));
				end
			end
			ST_ICMP: begin
				e_we = 1'b1;
				e_wa = AW'(lo_q + j_q);
				e_wd = (key_q < e_rd) ? e_rd : key_q;
			end
			ST_OUTR:  e_ra = idx_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD; cnt_q <= '0; sp_q <= '0; lo_q <= '0; n_q <= '0;
			idx_q <= '0; st_q <= '0; i_q <= '0; j_q <= '0; pk_q <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; piv_q <= '0; key_q <= '0; v_q <= '0; tmp_q <= '0;
			m_tvalid <= 1'b0; m_tdata <= '0; m_tlast <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: if (s_tvalid) begin
					if (cnt_q < DEPTH_C) cnt_q <= cnt_q + CW'(1);
					if (s_tlast) begin
						sp_q <= '0;
						lo_q <= '0;
						n_q <= (cnt_q < DEPTH_C) ? cnt_q + CW'(1) : cnt_q;
						state_q <= ST_SEG;
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						idx_q <= '0; state_q <= ST_OUTR;
					end else begin
						sp_q <= sp_q - CW'(1); state_q <= ST_POPW;
					end
				end
				ST_POPW: begin
					lo_q <= k_rd[2*CW-1:CW]; n_q <= k_rd[CW-1:0]; state_q <= ST_SEG;
				end
				ST_SEG: begin
					if (n_q < CW'(2)) state_q <= ST_POP;
					else if (n_q <= CUT_C) begin
						i_q <= CW'(1); state_q <= ST_II;
					end else state_q <= ST_MA;
				end
				ST_MA: begin a_q <= e_rd; state_q <= ST_MB; end
				ST_MB: begin b_q <= e_rd; state_q <= ST_MC; end
				ST_MC: begin c_q <= e_rd; state_q <= ST_MPICK; end
				ST_MPICK: begin
					piv_q <= pick_val; pk_q <= pick_idx; state_q <= ST_MSW;
				end
				ST_MSW: begin
					idx_q <= '0; st_q <= '0; state_q <= ST_PRD;
				end
				ST_PRD: state_q <= ST_PCMP;
				ST_PCMP: begin
					if (e_rd <= piv_q && st_q != idx_q) begin
						v_q <= e_rd; state_q <= ST_PSWA;
					end else begin
						if (e_rd <= piv_q) st_q <= st_q + CW'(1);
						idx_q <= idx_q + CW'(1);
						state_q <= last_scan ? ST_PFIN : ST_PRD;
					end
				end
				ST_PSWA: begin tmp_q <= e_rd; state_q <= ST_PSWB; end
				ST_PSWB: begin
					st_q <= st_q + CW'(1);
					idx_q <= idx_q + CW'(1);
					state_q <= last_scan ? ST_PFIN : ST_PRD;
				end
				ST_PFIN: state_q <= ST_PFA;
				ST_PFA:  state_q <= ST_PFB;
				ST_PFB:  state_q <= ST_PUSH1;
				ST_PUSH1: begin
					if (st_q >= CW'(2) && sp_q < DEPTH_C) sp_q <= sp_q + CW'(1);
					state_q <= ST_PUSH2;
				end
				ST_PUSH2: begin
					if (rlen >= CW'(2) && sp_q < DEPTH_C) sp_q <= sp_q + CW'(1);
					state_q <= ST_POP;
				end
				ST_II: begin
					if (i_q >= n_q) state_q <= ST_POP;
					else state_q <= ST_IKEY;
				end
				ST_IKEY: begin key_q <= e_rd; j_q <= i_q; state_q <= ST_ICMP; end
				ST_ICMP: begin
					if (key_q < e_rd) begin
						j_q <= j_q - CW'(1); state_q <= ST_IRD;
					end else begin
						i_q <= i_q + CW'(1); state_q <= ST_II;
					end
				end
				ST_IRD: begin
					if (j_q == '0) begin
						i_q <= i_q + CW'(1); state_q <= ST_II;
					end else state_q <= ST_ICMP;
				end
				ST_OUTR: state_q <= ST_OUTW;
				ST_OUTW: begin
					m_tvalid <= 1'b1;
					m_tdata <= e_rd ^ hqs_pkg::SIGN_FLIP;
					m_tlast <= (idx_q + CW'(1) == cnt_q);
					idx_q <= idx_q + CW'(1);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tlast) begin
							cnt_q <= '0; state_q <= ST_LOAD;
						end else state_q <= ST_OUTR;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// a waiting transfer holds its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast));
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid));
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C);
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= DEPTH_C);
endmodule
`default_nettype wire

// File: tb/hybrid_quicksort_engine_unit_tb.sv
`timescale 1ns / 1ps
module hybrid_quicksort_engine_unit_tb;
	localparam int DEPTH = 64;
	localparam int CUTOFF = 16;
	localparam int HOLD_LEN = 3000;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} elem_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	hybrid_quicksort_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	elem_t       pending_q[$];
	elem_t       sorted_q[$];
	logic [31:0] held[DEPTH];
	int          held_cnt = 0;
	int          seg_lo[$], seg_n[$];
	int          send_idle = 19, recv_idle = 82;
	bit          long_hold = 0;
	int          hold_cnt = 0;
	bit          failed = 0;

	// values held with the sign flipped so unsigned compare gives signed order
	function automatic void xchg(int a, int b);
		logic [31:0] t;
		t = held[a]; held[a] = held[b]; held[b] = t;
	endfunction

	task automatic insertion_run(int lo, int n);
		logic [31:0] key;
		int j;
		for (int i = 1; i < n; i++) begin
			key = held[lo + i];
			j = i;
			while (j > 0 && key < held[lo + j - 1]) begin
				held[lo + j] = held[lo + j - 1];
				j--;
			end
			held[lo + j] = key;
		end
	endtask

	function automatic int partition_at(int lo, int n);
		logic [31:0] a, b, c, piv;
		int pick, st;
		a = held[lo]; b = held[lo + n / 2]; c = held[lo + n - 1];
		if ((a <= b && b <= c) || (c <= b && b <= a)) pick = n / 2;
		else if ((a <= c && c <= b) || (b <= c && c <= a)) pick = n - 1;
		else pick = 0;
		xchg(lo + n - 1, lo + pick);
		piv = held[lo + n - 1];
		st = 0;
		for (int s = 0; s < n - 1; s++)
			if (held[lo + s] <= piv) begin
				xchg(lo + st, lo + s);
				st++;
			end
		xchg(lo + st, lo + n - 1);
		return st;
	endfunction

	task automatic push_seg(int lo, int n);
		if (n >= 2) begin
			seg_lo.push_back(lo);
			seg_n.push_back(n);
		end
	endtask

	task automatic predict_sorted(elem_t it);
		int lo, n, p;
		elem_t r;
		if (held_cnt < DEPTH) begin
			held[held_cnt] = it.value ^ hqs_pkg::SIGN_FLIP;
			held_cnt++;
		end
		if (!it.last) return;
		push_seg(0, held_cnt);
		while (seg_lo.size() > 0) begin
			lo = seg_lo.pop_back();
			n = seg_n.pop_back();
			if (n <= CUTOFF) insertion_run(lo, n);
			else begin
				p = partition_at(lo, n);
				push_seg(lo, p);
				push_seg(lo + p + 1, n - p - 1);
			end
		end
		for (int k = 0; k < held_cnt; k++) begin
			r.value = held[k] ^ hqs_pkg::SIGN_FLIP;
			r.last = (k + 1 == held_cnt);
			sorted_q.push_back(r);
		end
		held_cnt = 0;
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2: return $urandom_range(0, 8) - 4;
			3: return 32'd100 + $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_set(int n);
		elem_t it;
		for (int i = 0; i < n; i++) begin
			it.value = rand_val();
			it.last = (i == n - 1);
			pending_q.push_back(it);
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_sorted('{s_tdata, s_tlast});
			end
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					elem_t it;
					it = pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= it.value;
					s_tlast <= it.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver readiness, with one long hold-off counted here
	always @(posedge clk) begin
		if (long_hold && hold_cnt < HOLD_LEN) begin
			hold_cnt <= hold_cnt + 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_q.size() == 0) begin
				$display("%0t: unexpected transfer data=%h last=%b", $time, m_tdata, m_tlast);
				failed = 1;
			end else begin
				elem_t e;
				e = sorted_q.pop_front();
				if (e.value !== m_tdata) begin
					$display("%0t: sorted_value expected %h actual %h", $time, e.value, m_tdata);
					failed = 1;
				end
				if (e.last !== m_tlast) begin
					$display("%0t: last_res expected %b actual %b", $time, e.last, m_tlast);
					failed = 1;
				end
			end
		end
	end

	task automatic drain();
		while (pending_q.size() > 0 || s_tvalid || sorted_q.size() > 0) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed: single element, extremes, duplicates, descending
		pending_q.push_back('{32'h8000_0000, 1'b1});
		pending_q.push_back('{32'h7fff_ffff, 1'b0});
		pending_q.push_back('{32'h0000_0000, 1'b0});
		pending_q.push_back('{32'hffff_ffff, 1'b0});
		pending_q.push_back('{32'h8000_0000, 1'b0});
		pending_q.push_back('{32'h0000_0001, 1'b1});
		for (int i = 0; i < 17; i++) pending_q.push_back('{32'd5, i == 16});
		drain();
		for (int i = 0; i < 20; i++) pending_q.push_back('{32'd40 - i, i == 19});
		// store overflow: the last two values are dropped
		for (int i = 0; i < 66; i++) pending_q.push_back('{$urandom, i == 65});
		drain();
		// long receiver stall while sender keeps offering
		long_hold = 1;
		add_set(40);
		add_set(3);
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 19 : (ph == 1) ? 82 : 0;
			recv_idle = (ph == 0) ? 82 : (ph == 1) ? 19 : 0;
			for (int k = 0; k < 2; k++)
				add_set($urandom_range(1, 16));
			drain();
		end
		repeat (200) @(posedge clk);
		if (!failed && sorted_q.size() == 0) begin
			$display("hybrid_quicksort_engine_unit verification clean");
		end else begin
			$display("hybrid_quicksort_engine_unit verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("hybrid_quicksort_engine_unit verification failed");
		$finish;
	end
endmodule

// File: files.f
src/hqs_pkg.sv
src/hqs_ram.sv
src/hybrid_quicksort_engine_unit.sv
tb/hybrid_quicksort_engine_unit_tb.sv
